>>> design/arp_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared constants and types for the ARP cache resolver.
// ----------------------------------------------------------------------------
`default_nettype none
package arp_pkg;
	localparam int unsigned CacheEntries = 32;
	localparam int unsigned IdxW = $clog2(CacheEntries);
	localparam int unsigned CntW = $clog2(CacheEntries + 1);

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_ARP     = 2'd1;
	localparam logic [1:0] CMD_RESOLVE = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [0:0] REG_LOCAL_IP = 1'b0;
	localparam logic [0:0] REG_TIMEOUT  = 1'b1;

	localparam logic [31:0] BcastIp      = 32'hFFFF_FFFF;
	localparam logic [47:0] BcastMac     = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] MinArpLen    = 16'd28;
	localparam logic [15:0] HwEthernet   = 16'd1;
	localparam logic [15:0] ProtoIpv4    = 16'h0800;
	localparam logic [15:0] OpRequest    = 16'd1;
	localparam logic [15:0] OpReply      = 16'd2;
	localparam logic [31:0] TimeoutReset = 32'd60000;

	// Per-cell command from the controller.
	typedef struct packed {
		logic        load;
		logic        write;
		logic        kill;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] now;
	} cell_cmd_t;
endpackage
`default_nettype wire

>>> design/arp_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// One cache entry; compares the key handed along the row and forwards it.
// ----------------------------------------------------------------------------
`default_nettype none
module arp_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire arp_pkg::cell_cmd_t cmd,
	input  wire logic             sel,
	input  wire logic [31:0]      key_in,
	input  wire logic             act_in,
	input  wire logic [31:0]      timeout,
	output logic                  act_q,
	output logic [31:0]           key_q,
	output logic                  valid_q,
	output logic                  match,
	output logic                  stale,
	output logic [47:0]           mac
);
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] time_q;
	logic [31:0] age;

	assign age   = cmd.now - time_q;
	assign match = act_in && valid_q && (ip_q == key_in);
	assign stale = age > timeout;
	assign mac   = mac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			act_q <= act_in && !cmd.load;
			if (sel && cmd.write) begin
				valid_q <= 1'b1;
			end else if (sel && cmd.kill) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_in;
		if (sel && cmd.write) begin
			ip_q   <= cmd.ip;
			mac_q  <= cmd.mac;
			time_q <= cmd.now;
		end
	end
endmodule
`default_nettype wire

>>> design/arp_cache_resolver_core.sv
// ----------------------------------------------------------------------------
// ARP cache resolver core
// IP-to-MAC cache with millisecond aging, built as a row of entry cells.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  input    | in_valid/in_stall| command .. lookup_ip
//  output   | out_valid/out_stall | resolved .. insert_dropped
//  config   | cfg_we           | cfg_index, cfg_data
// A tick, rejected packet, unused command or broadcast query is answered in the
// cycle after it is accepted, and the next word can follow at once.
// An insert or a lookup walks the key down the row of 32 cells, one cell a cycle,
// stops at the first match, then gives its result from ST_DONE; no word is taken meanwhile.
// A result that waits on out_stall stalls the input until it is taken.
// Reset clears all valid bits at once.
`default_nettype none
module arp_cache_resolver_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] frame_length,
	input  wire logic [15:0] hw_type,
	input  wire logic [15:0] proto_type,
	input  wire logic [15:0] operation,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	input  wire logic [31:0] target_ip,
	input  wire logic [31:0] lookup_ip,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             resolved,
	output logic [47:0]      resolved_mac,
	output logic             send_request,
	output logic [31:0]      request_ip,
	output logic             send_reply,
	output logic [47:0]      reply_mac,
	output logic [31:0]      reply_ip,
	output logic             flush_pending,
	output logic             insert_dropped,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int unsigned N = arp_pkg::CacheEntries;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] now_q, local_ip_q, timeout_q;
	logic        is_insert_q;
	logic [31:0] key_q;
	logic [47:0] mac_in_q;
	logic        reply_q;
	logic [31:0] pos_q;
	logic [arp_pkg::IdxW-1:0] free_idx_q, hit_idx_q;
	logic        free_found_q, hit_q, hit_stale_q;
	logic [47:0] hit_mac_q;
	logic [arp_pkg::CntW-1:0] cnt_q;

	arp_pkg::cell_cmd_t ccmd;
	logic [N-1:0]  sel, act, valid, match, stale;
	logic [31:0]   keys [N];
	logic [47:0]   macs [N];
	logic [N:0]    act_chain;
	logic [31:0]   key_chain [N+1];

	logic accept, out_free, pkt_ok, any_match;
	logic go_scan, bcast_query, out_set;
	logic [arp_pkg::IdxW-1:0] cur;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign pkt_ok   = frame_length >= arp_pkg::MinArpLen && hw_type == arp_pkg::HwEthernet
		&& proto_type == arp_pkg::ProtoIpv4;
	assign bcast_query = command == arp_pkg::CMD_RESOLVE && lookup_ip == arp_pkg::BcastIp;
	assign go_scan  = (command == arp_pkg::CMD_ARP && pkt_ok)
		|| (command == arp_pkg::CMD_RESOLVE && lookup_ip != arp_pkg::BcastIp);
	assign out_set  = (state_q == ST_IDLE && accept && !go_scan)
		|| (state_q == ST_DONE && out_free);
	assign cur      = cnt_q[arp_pkg::IdxW-1:0];

	assign act_chain[0] = (state_q == ST_SCAN) && cnt_q == '0 && !ccmd.load;
	assign key_chain[0] = key_q;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			arp_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(ccmd), .sel(sel[g]),
				.key_in(key_chain[g]), .act_in(act_chain[g]), .timeout(timeout_q),
				.act_q(act[g]), .key_q(keys[g]), .valid_q(valid[g]),
				.match(match[g]), .stale(stale[g]), .mac(macs[g])
			);
			assign act_chain[g+1] = act[g];
			assign key_chain[g+1] = keys[g];
		end
	endgenerate

	// One cell is active per scan cycle; its result is at index cur.
	assign any_match = match[cur];

	always_comb begin
		ccmd.load  = 1'b0;
		ccmd.write = 1'b0;
		ccmd.kill  = 1'b0;
		ccmd.ip    = key_q;
		ccmd.mac   = mac_in_q;
		ccmd.now   = now_q;
		sel        = '0;
		if (state_q == ST_DONE) begin
			if (is_insert_q && (hit_q || free_found_q)) begin
				ccmd.write = 1'b1;
				sel[hit_q ? hit_idx_q : free_idx_q] = 1'b1;
			end else if (!is_insert_q && hit_q && hit_stale_q) begin
				ccmd.kill = 1'b1;
				sel[hit_idx_q] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			local_ip_q <= '0;
			timeout_q  <= arp_pkg::TimeoutReset;
			out_valid  <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == arp_pkg::REG_LOCAL_IP) local_ip_q <= cfg_data;
				else timeout_q <= cfg_data;
			end
			if (out_set) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (go_scan) state_q <= ST_SCAN;
						if (command == arp_pkg::CMD_TICK) now_q <= now_q + 32'd1;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == arp_pkg::CntW'(N - 1)
						|| (any_match)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				free_found_q <= 1'b0;
				hit_q        <= 1'b0;
				if (accept) begin
					is_insert_q <= command == arp_pkg::CMD_ARP;
					key_q       <= command == arp_pkg::CMD_ARP ? sender_ip : lookup_ip;
					mac_in_q    <= sender_mac;
					reply_q     <= operation == arp_pkg::OpRequest && target_ip == local_ip_q;
					pos_q       <= sender_ip;
					resolved       <= bcast_query;
					resolved_mac   <= bcast_query ? arp_pkg::BcastMac : '0;
					send_request   <= 1'b0;
					request_ip     <= '0;
					send_reply     <= 1'b0;
					reply_mac      <= '0;
					reply_ip       <= '0;
					flush_pending  <= 1'b0;
					insert_dropped <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (!valid[cur] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cur;
				end
				if (any_match) begin
					hit_q       <= 1'b1;
					hit_idx_q   <= cur;
					hit_stale_q <= stale[cur];
					hit_mac_q   <= macs[cur];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					if (is_insert_q) begin
						flush_pending  <= 1'b1;
						insert_dropped <= !hit_q && !free_found_q;
						send_reply     <= reply_q;
						reply_mac      <= reply_q ? mac_in_q : '0;
						reply_ip       <= reply_q ? pos_q : '0;
					end else if (hit_q && !hit_stale_q) begin
						resolved     <= 1'b1;
						resolved_mac <= hit_mac_q;
					end else begin
						send_request <= 1'b1;
						request_ip   <= key_q;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result lost");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(resolved && send_request)) else $error("hit and miss");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> in_stall) else $error("accepted while scanning");
	a_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel)) else $error("multiple cells written");
`endif
endmodule
`default_nettype wire
